// ===== src/srfc_pkg.sv =====
// ----------------------------------------------------------------------------
// srfc_pkg: shared types and constants for the servo reply frame checker
// Widths, header codes, register indexes and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package srfc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CrcW-1:0]  CrcPoly     = 16'h8005;
  localparam logic [ByteW-1:0] HdrSync     = 8'hFF;
  localparam logic [ByteW-1:0] HdrExt      = 8'hFD;
  localparam logic [ByteW-1:0] CountMax    = 8'hFF;
  localparam logic [ByteW-1:0] LengthReset = 8'd6;
  localparam logic [ByteW-1:0] HdrLenSum   = 8'd2;
  localparam logic [ByteW-1:0] HdrLenCrc   = 8'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegProtocolMode = 8'd0;
  localparam logic [CfgIdxW-1:0] RegFrameLength  = 8'd1;

  typedef enum logic {
    ModeSum = 1'b0,
    ModeCrc = 1'b1
  } srfc_mode_e;

  typedef struct packed {
    logic frame_ok;
    logic header_ok;
    logic length_ok;
    logic check_ok;
  } srfc_result_t;

  // CRC-16, poly 0x8005, MSB first, one byte per call
  function automatic logic [CrcW-1:0] crc16_step(logic [CrcW-1:0] crc,
                                                 logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[CrcW-1] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== src/srfc_if.sv =====
// ----------------------------------------------------------------------------
// srfc_if: valid/ready channels of the servo reply frame checker
// Received byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface srfc_byte_if;
  logic                        valid;
  logic                        ready;
  logic [srfc_pkg::ByteW-1:0]  byte_in;
  logic                        last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface srfc_result_if;
  logic valid;
  logic ready;
  logic frame_ok;
  logic header_ok;
  logic length_ok;
  logic check_ok;

  modport source (output valid, output frame_ok, output header_ok,
                  output length_ok, output check_ok, input ready);
  modport sink   (input valid, input frame_ok, input header_ok,
                  input length_ok, input check_ok, output ready);
endinterface

interface srfc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [srfc_pkg::CfgIdxW-1:0]  index;
  logic [srfc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/servo_reply_frame_checker.sv =====
// ----------------------------------------------------------------------------
// servo_reply_frame_checker: servo reply frame header/length/check verifier
// A last byte passes the input register and then the result register.
// Throughput: one byte per cycle, set by the combinational CRC byte step.
// A waiting result stalls a last byte in the input register and all bytes after it.
// Reset: async, active low; mode 0, frame length 6, frame state cleared.
// ----------------------------------------------------------------------------
module servo_reply_frame_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  srfc_byte_if.sink     byte_ch_i,
  srfc_result_if.source result_ch_o,
  srfc_cfg_if.sink      cfg_ch_i
);
  import srfc_pkg::*;

  // configuration
  srfc_mode_e       mode_q;
  logic [ByteW-1:0] frame_length_q;

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // result register
  logic             out_valid_q;
  srfc_result_t     out_res_q;

  logic             out_free;
  logic             advance;
  logic             in_xfer;
  srfc_result_t     verdict;

  assign out_free = !out_valid_q || result_ch_o.ready;
  assign advance  = in_valid_q && (!in_last_q || out_free);
  assign in_xfer  = byte_ch_i.valid && byte_ch_i.ready;

  assign byte_ch_i.ready = !in_valid_q || advance;
  assign cfg_ch_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ModeSum;
      frame_length_q <= LengthReset;
    end else if (cfg_ch_i.valid && cfg_ch_i.ready) begin
      if (cfg_ch_i.index == RegProtocolMode) begin
        mode_q <= srfc_mode_e'(cfg_ch_i.data[0]);
      end else if (cfg_ch_i.index == RegFrameLength) begin
        frame_length_q <= cfg_ch_i.data[ByteW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_ch_i.ready) begin
      in_valid_q <= byte_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= byte_ch_i.byte_in;
      in_last_q <= byte_ch_i.last_byte;
    end
  end

  srfc_frame_state u_frame_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .byte_i         (in_byte_q),
    .last_i         (in_last_q),
    .mode_i         (mode_q),
    .frame_length_i (frame_length_q),
    .result_o       (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_res_q <= verdict;
    end
  end

  assign result_ch_o.valid     = out_valid_q;
  assign result_ch_o.frame_ok  = out_res_q.frame_ok;
  assign result_ch_o.header_ok = out_res_q.header_ok;
  assign result_ch_o.length_ok = out_res_q.length_ok;
  assign result_ch_o.check_ok  = out_res_q.check_ok;

endmodule

// ===== src/srfc_frame_state.sv =====
// ----------------------------------------------------------------------------
// srfc_frame_state: per-frame state and end-of-frame verdict
// Tracks count, sum, CRC and header match; forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module srfc_frame_state (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [srfc_pkg::ByteW-1:0] byte_i,
  input  logic                       last_i,
  input  srfc_pkg::srfc_mode_e       mode_i,
  input  logic [srfc_pkg::ByteW-1:0] frame_length_i,
  output srfc_pkg::srfc_result_t     result_o
);
  import srfc_pkg::*;

  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [CrcW-1:0]  crc_lag_q, crc_lag_d;
  logic             hdr_match_q, hdr_match_d;
  logic             crc_low_q, crc_low_d;

  logic             hdr_bad;
  logic             hdr_now;
  logic [ByteW-1:0] total;
  logic [ByteW-1:0] hdr_len;
  logic             hdr_ok, len_ok, chk_ok;

  always_comb begin
    hdr_bad = ((count_q < HdrLenSum) && (byte_i != HdrSync)) ||
              ((count_q == HdrLenSum) && (mode_i == ModeCrc) && (byte_i != HdrExt));
    hdr_now = hdr_match_q && !hdr_bad;
    total   = (count_q == CountMax) ? CountMax : count_q + 8'd1;
    hdr_len = (mode_i == ModeCrc) ? HdrLenCrc : HdrLenSum;
    hdr_ok  = hdr_now && (total >= hdr_len);
    len_ok  = (total == frame_length_i);
    if (mode_i == ModeSum) begin
      chk_ok = (~sum_q == byte_i);
    end else begin
      chk_ok = crc_low_q && (crc_lag_q[CrcW-1:ByteW] == byte_i);
    end
    result_o.frame_ok  = hdr_ok && len_ok && chk_ok;
    result_o.header_ok = hdr_ok;
    result_o.length_ok = len_ok;
    result_o.check_ok  = chk_ok;
  end

  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    crc_d       = crc_q;
    crc_lag_d   = crc_lag_q;
    hdr_match_d = hdr_match_q;
    crc_low_d   = crc_low_q;
    if (step_i) begin
      if (last_i) begin
        count_d     = '0;
        sum_d       = '0;
        crc_d       = '0;
        crc_lag_d   = '0;
        hdr_match_d = 1'b1;
        crc_low_d   = 1'b0;
      end else begin
        if (count_q >= HdrLenSum) begin
          sum_d = sum_q + byte_i;
        end
        crc_low_d   = (crc_q[ByteW-1:0] == byte_i);
        crc_lag_d   = crc_q;
        crc_d       = crc16_step(crc_q, byte_i);
        hdr_match_d = hdr_now;
        if (count_q != CountMax) begin
          count_d = count_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      crc_q       <= '0;
      crc_lag_q   <= '0;
      hdr_match_q <= 1'b1;
      crc_low_q   <= 1'b0;
    end else begin
      count_q     <= count_d;
      sum_q       <= sum_d;
      crc_q       <= crc_d;
      crc_lag_q   <= crc_lag_d;
      hdr_match_q <= hdr_match_d;
      crc_low_q   <= crc_low_d;
    end
  end

endmodule

// ===== src/srfc_checker.sv =====
// ----------------------------------------------------------------------------
// srfc_checker: port-level checks for the servo reply frame checker
// Result channel rules, verdict consistency and last-byte result latency.
// ----------------------------------------------------------------------------
module srfc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic frame_ok_i,
  input logic header_ok_i,
  input logic length_ok_i,
  input logic check_ok_i
);

  logic in_last_xfer;
  assign in_last_xfer = in_valid_i && in_ready_i && in_last_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({frame_ok_i, header_ok_i,
                                             length_ok_i, check_ok_i}))
    else $error("result changed while stalled");

  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_ok_i == (header_ok_i && length_ok_i && check_ok_i)))
    else $error("frame_ok disagrees with its flags");

  // a last byte in the input register meeting an empty result register moves into it
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_xfer ##1 !out_valid_i |=> out_valid_i)
    else $error("last byte transfer gave no result");

endmodule

bind servo_reply_frame_checker srfc_checker u_srfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_ch_i.valid),
  .in_ready_i  (byte_ch_i.ready),
  .in_last_i   (byte_ch_i.last_byte),
  .out_valid_i (result_ch_o.valid),
  .out_ready_i (result_ch_o.ready),
  .frame_ok_i  (result_ch_o.frame_ok),
  .header_ok_i (result_ch_o.header_ok),
  .length_ok_i (result_ch_o.length_ok),
  .check_ok_i  (result_ch_o.check_ok)
);

// ===== verif/tb_servo_reply_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_reply_frame_checker: self-checking bench for the reply frame checker
// A directed table of frames followed by random frames under several settings
// and idle profiles. Every verdict is checked field by field against the
// table's expected verdict or an in-bench frame judge.
// ----------------------------------------------------------------------------
module tb_servo_reply_frame_checker;
  import srfc_pkg::*;

  typedef enum logic {
    RowByte,
    RowCfg
  } row_kind_e;

  // where a stimulus byte comes from; the check sources read the judge state
  typedef enum logic [2:0] {
    SrcLit,
    SrcSumInv,
    SrcCrcLo,
    SrcCrcHi,
    SrcCrcHiBad
  } byte_src_e;

  typedef struct {
    row_kind_e        kind;
    byte_src_e        src;
    logic [ByteW-1:0] val;   // byte value, or register data
    logic [7:0]       idx;
    logic             last;
    int               reps;
    bit               typed;
    srfc_result_t     want;  // {frame, header, length, check}
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  srfc_byte_if   byte_ch ();
  srfc_result_if res_ch ();
  srfc_cfg_if    cfg_ch ();

  servo_reply_frame_checker u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .byte_ch_i  (byte_ch),
    .result_ch_o(res_ch),
    .cfg_ch_i   (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // judge state: configuration and the frame in progress
  srfc_mode_e       cfg_mode;
  logic [ByteW-1:0] cfg_len;
  logic [ByteW-1:0] f_count;
  logic [ByteW-1:0] f_sum;
  logic [CrcW-1:0]  f_crc;
  logic [CrcW-1:0]  f_crc_lag;
  logic             f_hdr_good;
  logic             f_lo_good;

  srfc_result_t pending_verdicts[$];
  int fault_cnt      = 0;
  int bytes_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  function automatic logic [CrcW-1:0] crc_push(logic [CrcW-1:0] c, logic [ByteW-1:0] d);
    logic fb;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = c[CrcW-1] ^ d[i];
      c  = {c[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return c;
  endfunction

  function automatic void frame_clear();
    f_count    = '0;
    f_sum      = '0;
    f_crc      = '0;
    f_crc_lag  = '0;
    f_hdr_good = 1'b1;
    f_lo_good  = 1'b0;
  endfunction

  // returns 1 when the byte closes a frame, with its verdict in res
  function automatic bit judge_byte(input logic [ByteW-1:0] b, input logic last,
                                    output srfc_result_t res);
    logic [ByteW-1:0] total;
    logic [ByteW-1:0] hdr_len;
    res = '0;
    if (f_count < 2) begin
      if (b != HdrSync) f_hdr_good = 1'b0;
    end else if (f_count == 2 && cfg_mode == ModeCrc) begin
      if (b != HdrExt) f_hdr_good = 1'b0;
    end
    if (!last) begin
      if (f_count >= 2) f_sum = f_sum + b;
      f_lo_good = (f_crc[7:0] == b);
      f_crc_lag = f_crc;
      f_crc     = crc_push(f_crc, b);
      if (f_count != CountMax) f_count = f_count + 1'b1;
      return 1'b0;
    end
    total   = (f_count == CountMax) ? CountMax : f_count + 1'b1;
    hdr_len = (cfg_mode == ModeCrc) ? HdrLenCrc : HdrLenSum;
    res.header_ok = f_hdr_good && (total >= hdr_len);
    res.length_ok = (total == cfg_len);
    if (cfg_mode == ModeSum) res.check_ok = (~f_sum == b);
    else res.check_ok = f_lo_good && (f_crc_lag[15:8] == b);
    res.frame_ok = res.header_ok && res.length_ok && res.check_ok;
    frame_clear();
    return 1'b1;
  endfunction

  function automatic logic [ByteW-1:0] pick_byte(byte_src_e src, logic [ByteW-1:0] lit);
    case (src)
      SrcSumInv:   return ~f_sum;
      SrcCrcLo:    return f_crc[7:0];
      SrcCrcHi:    return f_crc_lag[15:8];
      SrcCrcHiBad: return ~f_crc_lag[15:8];
      default:     return lit;
    endcase
  endfunction

  function automatic stim_row_t byte_row(byte_src_e src, logic [ByteW-1:0] v, logic last,
                                         int reps);
    stim_row_t r;
    r.kind  = RowByte;
    r.src   = src;
    r.val   = v;
    r.idx   = '0;
    r.last  = last;
    r.reps  = reps;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t verdict_row(byte_src_e src, logic [ByteW-1:0] v,
                                            srfc_result_t want);
    stim_row_t r;
    r       = byte_row(src, v, 1'b1, 1);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [7:0] idx, logic [ByteW-1:0] data);
    stim_row_t r;
    r      = byte_row(SrcLit, data, 1'b0, 1);
    r.kind = RowCfg;
    r.idx  = idx;
    return r;
  endfunction

  // stop offering bytes and let every verdict come back
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last, input bit typed,
                           input srfc_result_t want);
    srfc_result_t verdict;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.byte_in   <= b;
    byte_ch.last_byte <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    if (judge_byte(b, last, verdict)) pending_verdicts.push_back(typed ? want : verdict);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [ByteW-1:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == RegProtocolMode) cfg_mode = srfc_mode_e'(data[0]);
    else if (idx == RegFrameLength) cfg_len = data;
  endtask

  // mostly well-formed frames; some corrupted, mis-sized or pure noise
  task automatic send_frame();
    int shape;
    int n;
    int hl;
    int bad_at;
    logic [ByteW-1:0] v;
    byte_src_e src;
    shape = $urandom_range(99);
    if (shape < 12) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1, 1'b0, '0);
    end else begin
      hl     = (cfg_mode == ModeCrc) ? 3 : 2;
      n      = cfg_len;
      if (shape < 24) n = (n > 1 && $urandom_range(1)) ? n - 1 : n + 1;
      bad_at = (shape >= 24 && shape < 36) ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == n - 1) src = (cfg_mode == ModeSum) ? SrcSumInv : SrcCrcHi;
        else if (cfg_mode == ModeCrc && i == n - 2) src = SrcCrcLo;
        else src = SrcLit;
        if (i < hl) v = (i == 2) ? HdrExt : HdrSync;
        else v = 8'($urandom_range(255));
        v = pick_byte(src, v);
        if (i == bad_at) v = v ^ (8'h01 << $urandom_range(7));
        send_byte(v, i == n - 1, 1'b0, '0);
      end
    end
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : verdict_mon
    srfc_result_t got;
    srfc_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.frame_ok, res_ch.header_ok, res_ch.length_ok, res_ch.check_ok};
      if (pending_verdicts.size() == 0) begin
        if (fault_cnt < 10) $display("unexpected verdict f/h/l/c=%b", got);
        fault_cnt++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.frame_ok !== want.frame_ok || got.header_ok !== want.header_ok ||
            got.length_ok !== want.length_ok || got.check_ok !== want.check_ok) begin
          if (fault_cnt < 10) begin
            $display("verdict mismatch f/h/l/c: expected %b actual %b", want, got);
          end
          fault_cnt++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t dir_rows[$];
    int goal;
    byte_ch.valid     = 1'b0;
    byte_ch.byte_in   = '0;
    byte_ch.last_byte = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    cfg_mode          = ModeSum;
    cfg_len           = LengthReset;
    frame_clear();
    send_idle_pct     = 16;
    recv_stall_pct    = 16;

    dir_rows = '{
      // reset setting: sum mode, six bytes
      byte_row(SrcLit, 8'hFF, 1'b0, 1), byte_row(SrcLit, 8'hFF, 1'b0, 1),
      byte_row(SrcLit, 8'h01, 1'b0, 1), byte_row(SrcLit, 8'h02, 1'b0, 1),
      byte_row(SrcLit, 8'h03, 1'b0, 1), verdict_row(SrcLit, 8'hF9, 4'b1111),
      // frame shorter than the header
      verdict_row(SrcLit, 8'hFF, 4'b0001),
      cfg_row(RegFrameLength, 8'h00),
      byte_row(SrcLit, 8'hFF, 1'b0, 1), byte_row(SrcLit, 8'hFF, 1'b0, 1),
      byte_row(SrcLit, 8'h00, 1'b0, 1), verdict_row(SrcLit, 8'hFF, 4'b0101),
      // single byte in CRC mode never passes the check
      cfg_row(RegProtocolMode, 8'h01),
      verdict_row(SrcLit, 8'h00, 4'b0000),
      // upper data bits ignored; long frame saturates the count at 255
      cfg_row(RegProtocolMode, 8'hFE), cfg_row(RegFrameLength, 8'hFF),
      byte_row(SrcLit, 8'hFF, 1'b0, 1), byte_row(SrcLit, 8'hFF, 1'b0, 1),
      byte_row(SrcLit, 8'h00, 1'b0, 300), verdict_row(SrcLit, 8'hFF, 4'b1111),
      // mode switched between header bytes
      cfg_row(RegFrameLength, 8'd6),
      byte_row(SrcLit, 8'hFF, 1'b0, 1), byte_row(SrcLit, 8'hFF, 1'b0, 1),
      cfg_row(RegProtocolMode, 8'h01),
      byte_row(SrcLit, HdrExt, 1'b0, 1), byte_row(SrcLit, 8'h80, 1'b0, 1),
      byte_row(SrcCrcLo, 8'h00, 1'b0, 1), byte_row(SrcCrcHi, 8'h00, 1'b1, 1),
      // CRC high byte wrong
      byte_row(SrcLit, 8'hFF, 1'b0, 1), byte_row(SrcLit, 8'hFF, 1'b0, 1),
      byte_row(SrcLit, HdrExt, 1'b0, 1), byte_row(SrcLit, 8'h7F, 1'b0, 1),
      byte_row(SrcCrcLo, 8'h00, 1'b0, 1), verdict_row(SrcCrcHiBad, 8'h00, 4'b0110)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        for (int k = 0; k < dir_rows[r].reps; k++) begin
          send_byte(pick_byte(dir_rows[r].src, dir_rows[r].val), dir_rows[r].last,
                    dir_rows[r].typed, dir_rows[r].want);
        end
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 64;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 64;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      write_reg(RegProtocolMode, {7'($urandom), ph[0]});
      write_reg(RegFrameLength, 8'($urandom_range(cfg_mode == ModeCrc ? 5 : 3, 16)));
      // long receiver hold-off while bytes keep coming: input must back up
      if (ph == 0) hold_left = 300;
      goal = bytes_sent + 120;
      while (bytes_sent < goal) begin
        send_frame();
        // sender waits out every outstanding verdict after each frame ending in a window
        if (ph == 2 && bytes_sent >= goal - 100 && bytes_sent < goal - 80) drain();
      end
    end

    drain();
    if (fault_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/srfc_pkg.sv
src/srfc_if.sv
src/srfc_frame_state.sv
src/servo_reply_frame_checker.sv
src/srfc_checker.sv
verif/tb_servo_reply_frame_checker.sv
